[sv/autocorrelation_pitch_detector_defines.svh]
// ----------------------------------------------------------------------------
// Autocorrelation pitch detector assertion macros
// Property wrappers clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef AUTOCORRELATION_PITCH_DETECTOR_DEFINES_SVH
`define AUTOCORRELATION_PITCH_DETECTOR_DEFINES_SVH

`ifndef ASSERT_OFF
// Same-cycle implication.
`define APD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("apd: property violated");
// Next-cycle implication.
`define APD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("apd: property violated");
`else
`define APD_ASSERT_IMP(lbl, ante, cons)
`define APD_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

[sv/apd_pkg.sv]
// ----------------------------------------------------------------------------
// Autocorrelation pitch detector package
// Widths, register indexes, state encoding and pipeline tag type.
// ----------------------------------------------------------------------------
`default_nettype none

package apd_pkg;

  localparam int WINDOW_DEPTH = 4096;
  localparam int ADDR_W       = $clog2(WINDOW_DEPTH);
  localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);

  localparam int SAMPLE_W = 16;
  localparam int PROD_W   = 2 * SAMPLE_W;
  localparam int LAG_W    = 12;
  localparam int RATE_W   = 18;
  localparam int SUM_W    = 44;
  localparam int SCORE_W  = 43;
  localparam int FREQ_W   = RATE_W + 8;
  localparam int DIV_CNT_W = $clog2(FREQ_W);

  // Lag and sample index arithmetic share one width.
  localparam int IDX_W = (CNT_W > LAG_W) ? CNT_W : LAG_W;

  localparam int IN_TDATA_W   = SAMPLE_W;
  localparam int OUT_FIELDS_W = LAG_W + SCORE_W + FREQ_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam int CFG_AW    = 4;
  localparam int CFG_DW    = 32;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_LAG_MIN     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LAG_MAX     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE = 2'd2;

  localparam logic [LAG_W-1:0]  LAG_MIN_RST     = 12'd16;
  localparam logic [LAG_W-1:0]  LAG_MAX_RST     = 12'd1200;
  localparam logic [RATE_W-1:0] SAMPLE_RATE_RST = 18'd48000;

  typedef enum logic [5:0] {
    ST_LOAD   = 6'b000001,
    ST_SETUP  = 6'b000010,
    ST_SEARCH = 6'b000100,
    ST_DRAIN  = 6'b001000,
    ST_DIVIDE = 6'b010000,
    ST_RESULT = 6'b100000
  } apd_state_t;

  // Tag that travels with each product through the multiply-accumulate pipe.
  typedef struct packed {
    logic             vld;
    logic             last;
    logic [LAG_W-1:0] lag;
  } apd_tag_t;

endpackage

`default_nettype wire

[sv/autocorrelation_pitch_detector.sv]
// ----------------------------------------------------------------------------
// Autocorrelation pitch detector
// Loads a window of Q1.15 samples, searches the autocorrelation peak over a
// lag range and reports the winning lag, its score and the frequency in Q8.
// ----------------------------------------------------------------------------
// Samples are taken one per cycle into the window memory while the detector
// is loading; the transaction with tlast set closes the window (samples past
// the memory depth are dropped) and starts the search. After a setup state,
// the search runs one multiply-accumulate per cycle, reading both operands
// from two copies of the window memory; the pipeline drain, then, when a lag
// was found, a bit-serial division for the frequency, then the posting of the
// result follow in that order. No input is taken from the closing sample
// until the result is posted; a posted result waits in the output register
// while the next window loads. A window with no strictly positive sum, or an
// empty lag range, yields one all-zero result.
`default_nettype none
`include "autocorrelation_pitch_detector_defines.svh"

module autocorrelation_pitch_detector (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // in_tdata: sample[15:0]
  input  wire logic [apd_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  wire logic                            in_tlast,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // out_tdata: best_lag[11:0], best_score[54:12], frequency_q8[80:55], zeros
  output logic [apd_pkg::OUT_TDATA_W-1:0]      out_tdata,
  // out_tuser: found[0]
  output logic                                 out_tuser,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  input  wire logic                            cfg_psel,
  input  wire logic                            cfg_penable,
  input  wire logic                            cfg_pwrite,
  input  wire logic [apd_pkg::CFG_AW-1:0]      cfg_paddr,
  input  wire logic [apd_pkg::CFG_DW-1:0]      cfg_pwdata,
  output logic [apd_pkg::CFG_DW-1:0]           cfg_prdata,
  output logic                                 cfg_pready
);

  import apd_pkg::*;

  apd_state_t state_r, state_nxt;

  logic [LAG_W-1:0]  lag_min_r, lag_max_r;
  logic [RATE_W-1:0] rate_r;
  logic [CNT_W-1:0]  count_r;

  logic [IDX_W-1:0] lag_r, i_r, hi_r;
  logic [IDX_W-1:0] lo, hi, cnt_m1, j_idx;
  logic             term_last;

  apd_tag_t s1_r, s2_r;

  logic signed [SAMPLE_W-1:0] rd_a, rd_b;
  logic signed [PROD_W-1:0]   prod_r;
  logic signed [SUM_W-1:0]    acc_r, best_r, total;
  logic [LAG_W-1:0]           best_lag_r;

  logic [FREQ_W-1:0]    div_q_r;
  logic [LAG_W-1:0]     rem_r;
  logic [DIV_CNT_W-1:0] div_cnt_r;
  logic [LAG_W:0]       rem_sh, rem_diff;
  logic                 rem_ge;

  logic                out_valid_r, out_found_r;
  logic [LAG_W-1:0]    out_lag_r;
  logic [SCORE_W-1:0]  out_score_r;
  logic [FREQ_W-1:0]   out_freq_r;

  logic in_acc, wr_en, cfg_we, post;
  logic [CFG_IDX_W-1:0] cfg_idx;

  assign in_tready = (state_r == ST_LOAD);
  assign in_acc    = in_tvalid & in_tready;
  assign wr_en     = in_acc & (count_r < CNT_W'(WINDOW_DEPTH));
  assign post      = (state_r == ST_RESULT) & (~out_valid_r | out_tready);

  assign cfg_idx    = cfg_paddr[CFG_IDX_W+1:2];
  assign cfg_we     = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_comb begin
    case (cfg_idx)
      REG_LAG_MIN:     cfg_prdata = CFG_DW'(lag_min_r);
      REG_LAG_MAX:     cfg_prdata = CFG_DW'(lag_max_r);
      REG_SAMPLE_RATE: cfg_prdata = CFG_DW'(rate_r);
      default:         cfg_prdata = '0;
    endcase
  end

  // Lag range: a zero lag_min searches from lag one; the top is clipped to
  // the window length minus one.
  assign lo     = (lag_min_r == '0) ? IDX_W'(1) : IDX_W'(lag_min_r);
  assign cnt_m1 = IDX_W'(count_r) - IDX_W'(1);
  assign hi     = (IDX_W'(lag_max_r) < cnt_m1) ? IDX_W'(lag_max_r) : cnt_m1;

  assign j_idx     = i_r + lag_r;
  assign term_last = (j_idx == cnt_m1);

  apd_ram #(.WIDTH(SAMPLE_W), .DEPTH(WINDOW_DEPTH)) u_ram_a (
    .clk   (clk),
    .we    (wr_en),
    .waddr (count_r[ADDR_W-1:0]),
    .wdata (in_tdata[SAMPLE_W-1:0]),
    .raddr (i_r[ADDR_W-1:0]),
    .rdata (rd_a)
  );

  apd_ram #(.WIDTH(SAMPLE_W), .DEPTH(WINDOW_DEPTH)) u_ram_b (
    .clk   (clk),
    .we    (wr_en),
    .waddr (count_r[ADDR_W-1:0]),
    .wdata (in_tdata[SAMPLE_W-1:0]),
    .raddr (j_idx[ADDR_W-1:0]),
    .rdata (rd_b)
  );

  assign total = acc_r + SUM_W'(prod_r);

  // Restoring division step of sample_rate*256 by the winning lag.
  assign rem_sh   = {rem_r, div_q_r[FREQ_W-1]};
  assign rem_ge   = (rem_sh >= {1'b0, best_lag_r});
  assign rem_diff = rem_sh - {1'b0, best_lag_r};

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_LOAD: begin
        if (in_acc && in_tlast) state_nxt = ST_SETUP;
      end
      ST_SETUP: begin
        state_nxt = (lo > hi) ? ST_RESULT : ST_SEARCH;
      end
      ST_SEARCH: begin
        if (term_last && (lag_r == hi_r)) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!s1_r.vld && !s2_r.vld) begin
          state_nxt = (best_lag_r == '0) ? ST_RESULT : ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (div_cnt_r == DIV_CNT_W'(FREQ_W - 1)) state_nxt = ST_RESULT;
      end
      ST_RESULT: begin
        if (post) state_nxt = ST_LOAD;
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      lag_min_r   <= LAG_MIN_RST;
      lag_max_r   <= LAG_MAX_RST;
      rate_r      <= SAMPLE_RATE_RST;
      count_r     <= '0;
      s1_r        <= '0;
      s2_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_idx)
          REG_LAG_MIN:     lag_min_r <= cfg_pwdata[LAG_W-1:0];
          REG_LAG_MAX:     lag_max_r <= cfg_pwdata[LAG_W-1:0];
          REG_SAMPLE_RATE: rate_r    <= cfg_pwdata[RATE_W-1:0];
          default: ;
        endcase
      end
      if (wr_en) begin
        count_r <= count_r + CNT_W'(1);
      end else if (state_r == ST_RESULT) begin
        count_r <= '0;
      end
      s1_r.vld  <= (state_r == ST_SEARCH);
      s1_r.last <= term_last;
      s1_r.lag  <= lag_r[LAG_W-1:0];
      s2_r      <= s1_r;
      if (post) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= rd_a * rd_b;

    if (state_r == ST_SETUP) begin
      lag_r      <= lo;
      i_r        <= '0;
      hi_r       <= hi;
      acc_r      <= '0;
      best_r     <= '0;
      best_lag_r <= '0;
    end

    if (state_r == ST_SEARCH) begin
      if (term_last) begin
        i_r   <= '0;
        lag_r <= lag_r + IDX_W'(1);
      end else begin
        i_r <= i_r + IDX_W'(1);
      end
    end

    // The first lag reaching the largest strictly positive sum wins.
    if (s2_r.vld) begin
      if (s2_r.last) begin
        acc_r <= '0;
        if (total > best_r) begin
          best_r     <= total;
          best_lag_r <= s2_r.lag;
        end
      end else begin
        acc_r <= total;
      end
    end

    if (state_r == ST_DRAIN) begin
      div_q_r   <= {rate_r, 8'd0};
      rem_r     <= '0;
      div_cnt_r <= '0;
    end else if (state_r == ST_DIVIDE) begin
      div_q_r   <= {div_q_r[FREQ_W-2:0], rem_ge};
      rem_r     <= rem_ge ? rem_diff[LAG_W-1:0] : rem_sh[LAG_W-1:0];
      div_cnt_r <= div_cnt_r + DIV_CNT_W'(1);
    end

    if (post) begin
      out_found_r <= (best_lag_r != '0);
      out_lag_r   <= best_lag_r;
      out_score_r <= (best_lag_r != '0) ? best_r[SCORE_W-1:0] : '0;
      out_freq_r  <= (best_lag_r != '0) ? div_q_r : '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_found_r;
  assign out_tdata  = OUT_TDATA_W'({out_freq_r, out_score_r, out_lag_r});

  `APD_ASSERT_IMP(a_mac_only_in_search, s2_r.vld,
                  (state_r == ST_SEARCH) || (state_r == ST_DRAIN))
  `APD_ASSERT_IMP(a_read_inside_window, state_r == ST_SEARCH,
                  j_idx < IDX_W'(count_r))
  `APD_ASSERT_IMP(a_divide_needs_lag, state_r == ST_DIVIDE, best_lag_r != '0)
  `APD_ASSERT_NXT(a_no_load_while_busy, (state_r == ST_SETUP) && (lo <= hi),
                  !in_tready)

endmodule

`default_nettype wire

[sv/apd_ram.sv]
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module apd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[bench/apd_pitch_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pitch detector result checker
// Follows register writes and sample transactions, works out the pitch result
// of every closed window and compares each result transaction field by field.
// ----------------------------------------------------------------------------
module apd_pitch_checker
  import apd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   in_tlast,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   out_tuser,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [CFG_AW-1:0]      cfg_paddr,
  input  logic [CFG_DW-1:0]      cfg_pwdata,
  input  logic                   cfg_pready,
  output int unsigned            pending,
  output int unsigned            fail_count
);

  typedef struct packed {
    logic               found;
    logic [LAG_W-1:0]   lag;
    logic [SCORE_W-1:0] score;
    logic [FREQ_W-1:0]  freq;
  } pitch_t;

  logic signed [SAMPLE_W-1:0] window_mem [WINDOW_DEPTH];
  int unsigned                window_fill;
  logic [LAG_W-1:0]           lag_min_cfg;
  logic [LAG_W-1:0]           lag_max_cfg;
  logic [RATE_W-1:0]          rate_cfg;
  pitch_t                     pitch_queue [$];

  task automatic report_error(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    fail_count++;
  endtask

  // Exhaustive lag search over the samples held in the current window.
  function automatic pitch_t predict_pitch();
    int unsigned lo;
    int unsigned hi;
    int unsigned lag;
    int unsigned i;
    longint      acc;
    longint      best;
    pitch_t      res;
    lo = (lag_min_cfg == 0) ? 1 : lag_min_cfg;
    hi = lag_max_cfg;
    if (window_fill == 0) begin
      hi = 0;
    end else if (window_fill - 1 < hi) begin
      hi = window_fill - 1;
    end
    best = 0;
    res  = '0;
    for (lag = lo; lag <= hi; lag++) begin
      acc = 0;
      for (i = 0; i + lag < window_fill; i++) begin
        acc += longint'(window_mem[i]) * longint'(window_mem[i + lag]);
      end
      // Strictly greater keeps the first lag among equal sums.
      if (acc > best) begin
        best    = acc;
        res.lag = lag[LAG_W-1:0];
      end
    end
    if (res.lag != 0) begin
      res.found = 1'b1;
      res.score = best[SCORE_W-1:0];
      res.freq  = FREQ_W'((64'(rate_cfg) << 8) / 64'(res.lag));
    end
    return res;
  endfunction

  task automatic check_pitch(input pitch_t want);
    pitch_t got;
    got.found = out_tuser;
    got.lag   = out_tdata[LAG_W-1:0];
    got.score = out_tdata[LAG_W +: SCORE_W];
    got.freq  = out_tdata[LAG_W+SCORE_W +: FREQ_W];
    if (got.found !== want.found) begin
      report_error($sformatf("found: got %0d, expected %0d", got.found, want.found));
    end
    if (got.lag !== want.lag) begin
      report_error($sformatf("best_lag: got %0d, expected %0d", got.lag, want.lag));
    end
    if (got.score !== want.score) begin
      report_error($sformatf("best_score: got %0d, expected %0d", got.score, want.score));
    end
    if (got.freq !== want.freq) begin
      report_error($sformatf("frequency_q8: got %0d, expected %0d", got.freq, want.freq));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      window_fill = 0;
      lag_min_cfg = LAG_MIN_RST;
      lag_max_cfg = LAG_MAX_RST;
      rate_cfg    = SAMPLE_RATE_RST;
      pitch_queue.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[CFG_AW-1:2])
          REG_LAG_MIN:     lag_min_cfg = cfg_pwdata[LAG_W-1:0];
          REG_LAG_MAX:     lag_max_cfg = cfg_pwdata[LAG_W-1:0];
          REG_SAMPLE_RATE: rate_cfg    = cfg_pwdata[RATE_W-1:0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        if (pitch_queue.size() == 0) begin
          report_error("result transaction with no window pending");
        end else begin
          check_pitch(pitch_queue.pop_front());
        end
      end
      if (in_tvalid && in_tready) begin
        // Samples beyond the window depth are dropped.
        if (window_fill < WINDOW_DEPTH) begin
          window_mem[window_fill] = in_tdata;
          window_fill++;
        end
        if (in_tlast) begin
          pitch_queue.push_back(predict_pitch());
          window_fill = 0;
        end
      end
    end
    pending = pitch_queue.size();
  end

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Autocorrelation pitch detector testbench
// Drives directed and random sample windows through the detector under
// changing lag ranges and sample rates, with random stalls on both streams.
// ----------------------------------------------------------------------------
module testbench;
  import apd_pkg::*;

  localparam int unsigned STALL_LIMIT = 60000;
  localparam int unsigned HOLD_CYCLES = 3000;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   in_tlast = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic                   cfg_psel = 1'b0;
  logic                   cfg_penable = 1'b0;
  logic                   cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0]      cfg_paddr = '0;
  logic [CFG_DW-1:0]      cfg_pwdata = '0;
  logic [CFG_DW-1:0]      cfg_prdata;
  logic                   cfg_pready;

  int unsigned pending;
  int unsigned fail_count;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  logic        hold_start = 1'b0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  autocorrelation_pitch_detector i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  apd_pitch_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_pready  (cfg_pready),
    .pending     (pending),
    .fail_count  (fail_count)
  );

  // Result sink: random stalls, plus a long hold-off when requested.
  always @(posedge clk) begin
    if (hold_start) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
    out_tready <= !hold_start && hold_left == 0 && ($urandom_range(0, 99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic put_sample(input logic [IN_TDATA_W-1:0] value, input logic last);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    in_tlast  <= last;
    // Ready is stable mid-cycle; the transaction completes at the next edge.
    @(negedge clk);
    while (!in_tready) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DW-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_AW'({idx, 2'b00});
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    while (!cfg_pready) @(negedge clk);
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain_results;
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic shuffle_config;
    int unsigned lo;
    int unsigned hi;
    int unsigned rate;
    case ($urandom_range(0, 5))
      0:       lo = 0;
      1:       lo = 1;
      2:       lo = 4095;
      default: lo = $urandom_range(1, 20);
    endcase
    case ($urandom_range(0, 5))
      0:       hi = 4095;
      1:       hi = $urandom_range(1, 8);
      default: hi = lo + $urandom_range(0, 40);
    endcase
    if (hi > 4095) hi = 4095;
    if (hi == 0) hi = 1;
    case ($urandom_range(0, 3))
      0:       rate = 8000;
      1:       rate = 192000;
      default: rate = $urandom_range(8000, 192000);
    endcase
    write_reg(REG_LAG_MIN, lo);
    write_reg(REG_LAG_MAX, hi);
    write_reg(REG_SAMPLE_RATE, rate);
  endtask

  // One window: noise, a noisy repeating motif, tiny values or a square wave.
  task automatic send_window(input int unsigned len);
    logic [IN_TDATA_W-1:0] motif [16];
    logic [IN_TDATA_W-1:0] value;
    int unsigned           kind;
    int unsigned           period;
    int unsigned           n;
    kind   = $urandom_range(0, 3);
    period = $urandom_range(2, 16);
    for (n = 0; n < 16; n++) motif[n] = 16'($urandom);
    for (n = 0; n < len; n++) begin
      case (kind)
        0:       value = 16'($urandom);
        1:       value = motif[n % period] ^ 16'($urandom_range(0, 15));
        2:       value = 16'($urandom_range(0, 8)) - 16'd4;
        default: value = (n % period < period / 2) ? 16'h7FFF : 16'h8000;
      endcase
      put_sample(value, n == len - 1);
    end
  endtask

  task automatic run_traffic(input int unsigned tx_pct, input int unsigned rx_pct,
                             input bit squeeze);
    int unsigned sent;
    int unsigned windows;
    int unsigned len;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    sent        = 0;
    windows     = 0;
    while (sent < 170 || windows < 15) begin
      if (windows % 4 == 0) begin
        drain_results;
        shuffle_config;
      end
      // Hold the sink off so a finished result backs up into the input.
      if (squeeze && windows == 4) begin
        hold_start <= 1'b1;
        @(posedge clk);
        hold_start <= 1'b0;
      end
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 120) : $urandom_range(1, 24);
      send_window(len);
      sent += len;
      windows++;
    end
    drain_results;
  endtask

  initial begin
    int unsigned n;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_reg(REG_LAG_MIN, 1);
    write_reg(REG_LAG_MAX, 4095);
    write_reg(REG_SAMPLE_RATE, 192000);
    // A single sample leaves no lag to search.
    put_sample(16'h8000, 1'b1);
    put_sample(16'h5555, 1'b0);
    put_sample(16'hAAAA, 1'b0);
    put_sample(16'h5555, 1'b0);
    put_sample(16'hAAAA, 1'b1);
    // Only a negative sum, so nothing is found.
    put_sample(16'd5, 1'b0);
    put_sample(16'hFFFB, 1'b1);
    repeat (4) put_sample(16'h7FFF, 1'b0);
    put_sample(16'h7FFF, 1'b1);
    // Lags one to three give equal sums; the first must win.
    put_sample(16'd1, 1'b0);
    put_sample(16'd1, 1'b0);
    put_sample(16'd0, 1'b0);
    put_sample(16'd1, 1'b1);
    drain_results;

    // A zero minimum lag is searched from lag one.
    write_reg(REG_LAG_MIN, 0);
    write_reg(REG_SAMPLE_RATE, 8000);
    put_sample(16'd100, 1'b0);
    put_sample(16'd100, 1'b0);
    put_sample(16'd100, 1'b1);
    drain_results;

    // Minimum above maximum: empty lag range.
    write_reg(REG_LAG_MIN, 5);
    write_reg(REG_LAG_MAX, 2);
    put_sample(16'h7FFF, 1'b0);
    put_sample(16'h7FFF, 1'b0);
    put_sample(16'h7FFF, 1'b1);
    drain_results;

    // Overfill the window; the extra samples must be dropped. Only the
    // longest lags are searched to keep the run short.
    write_reg(REG_LAG_MIN, 4000);
    write_reg(REG_LAG_MAX, 4095);
    for (n = 0; n < WINDOW_DEPTH + 4; n++) begin
      if (n < WINDOW_DEPTH) begin
        put_sample(16'($urandom_range(0, 32767)), 1'b0);
      end else begin
        put_sample(16'h8000, n == WINDOW_DEPTH + 3);
      end
    end
    drain_results;

    run_traffic(25, 74, 1'b0);
    run_traffic(74, 25, 1'b0);
    run_traffic(0, 0, 1'b1);

    repeat (40) @(posedge clk);
    @(negedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
